### rtl/ffed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffed_pkg
// Shared types and constants for the filtered feedback echo delay core.
// ----------------------------------------------------------------------------
package ffed_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 26;
  localparam int STATE_W    = 32;
  localparam int DELAY_W    = 17;
  localparam int CFG_W      = 26;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_DELAY_DEF    = 65536;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam logic [DELAY_W-1:0]         DELAY_RST = 17'd24000;
  localparam logic signed [SAMPLE_W-1:0] FB_RST    = 24'sd0;
  localparam logic [SAMPLE_W-1:0]        MIX_RST   = 24'd4194304;
  localparam logic signed [COEF_W-1:0]   B0_RST    = 26'sd4194304;
  localparam logic signed [COEF_W-1:0]   COEF_ZERO = 26'sd0;
  localparam logic [SAMPLE_W-1:0]        UNITY_Q23 = 24'd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 3'd0,
    REG_FEEDBACK = 3'd1,
    REG_MIX      = 3'd2,
    REG_B0       = 3'd3,
    REG_B1       = 3'd4,
    REG_B2       = 3'd5,
    REG_A1       = 3'd6,
    REG_A2       = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_FILT,
    S_MUL2,
    S_WB
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       chan_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       chan_out;
  } out_word_t;

endpackage

### rtl/filtered_feedback_echo_delay_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_feedback_echo_delay_core
// Per-channel echo with a biquad filter in the feedback path.
//
// Input words (sample, channel) arrive on in_valid/in_ready and each one
// yields exactly one output word on out_valid/out_ready, in order. A word
// reads the delayed sample and the filter state from block memories at the
// accept edge, runs through four sequencer steps (coefficient products,
// filter output, loop and mix products, write back) and presents its result
// at write back. The next word can be accepted in the cycle
// after write back, so a new word waits until the previous one is through,
// set by the shared read-modify-write of the echo and filter-state memories.
// The output register parts the two sides: a new word is accepted while the
// previous result waits; a stalled receiver holds the sequencer in write
// back until the output register frees up.
// Reset clears pointers and filter state valid bits, presets config regs.
// Echo memory entries not yet written since reset read as zero by a
// per-channel fill pointer and wrap flag, so no clearing pass is needed.
// Config writes act at once; the user must write only while idle, unenforced.
// ----------------------------------------------------------------------------
module filtered_feedback_echo_delay_core #(
  parameter int MAX_DELAY    = ffed_pkg::MAX_DELAY_DEF,
  parameter int NUM_CHANNELS = ffed_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ffed_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ffed_pkg::out_word_t                  out_word,
  input  logic                                 cfg_we,
  input  logic [ffed_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ffed_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PW  = $clog2(MAX_DELAY);
  localparam int DW  = (PW + 1 > ffed_pkg::DELAY_W) ? PW + 1 : ffed_pkg::DELAY_W;
  localparam int AW  = $clog2(NUM_CHANNELS * MAX_DELAY);
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW  = ffed_pkg::SAMPLE_W;
  localparam int TW  = ffed_pkg::STATE_W;

  function automatic logic signed [SW-1:0] sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      return 24'sh800000;
    end
    return v[SW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[TW-1:0];
  endfunction

  function automatic logic [AW-1:0] echo_addr(input logic ch, input logic [PW-1:0] ptr);
    return ch ? AW'(MAX_DELAY) + AW'(ptr) : AW'(ptr);
  endfunction

  // config registers
  logic [ffed_pkg::DELAY_W-1:0]        delay_samples;
  logic signed [SW-1:0]                feedback_level;
  logic [SW-1:0]                       mix_level;
  logic signed [ffed_pkg::COEF_W-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= ffed_pkg::DELAY_RST;
      feedback_level <= ffed_pkg::FB_RST;
      mix_level      <= ffed_pkg::MIX_RST;
      coef_b0        <= ffed_pkg::B0_RST;
      coef_b1        <= ffed_pkg::COEF_ZERO;
      coef_b2        <= ffed_pkg::COEF_ZERO;
      coef_a1        <= ffed_pkg::COEF_ZERO;
      coef_a2        <= ffed_pkg::COEF_ZERO;
    end else if (cfg_we) begin
      unique case (ffed_pkg::cfg_reg_t'(cfg_index))
        ffed_pkg::REG_DELAY:    delay_samples  <= cfg_data[ffed_pkg::DELAY_W-1:0];
        ffed_pkg::REG_FEEDBACK: feedback_level <= cfg_data[SW-1:0];
        ffed_pkg::REG_MIX:      mix_level      <= cfg_data[SW-1:0];
        ffed_pkg::REG_B0:       coef_b0        <= cfg_data;
        ffed_pkg::REG_B1:       coef_b1        <= cfg_data;
        ffed_pkg::REG_B2:       coef_b2        <= cfg_data;
        ffed_pkg::REG_A1:       coef_a1        <= cfg_data;
        ffed_pkg::REG_A2:       coef_a2        <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  ffed_pkg::state_t state, state_next;
  logic in_fire, wb_fire, echo_we, bq_we;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ffed_pkg::S_IDLE: if (in_fire) state_next = ffed_pkg::S_MUL1;
      ffed_pkg::S_MUL1: state_next = ffed_pkg::S_FILT;
      ffed_pkg::S_FILT: state_next = ffed_pkg::S_MUL2;
      ffed_pkg::S_MUL2: state_next = ffed_pkg::S_WB;
      ffed_pkg::S_WB:   if (wb_fire) state_next = ffed_pkg::S_IDLE;
      default:          state_next = ffed_pkg::S_IDLE;
    endcase
  end

  logic bypass;

  always_comb begin
    in_ready = (state == ffed_pkg::S_IDLE);
    wb_fire  = (state == ffed_pkg::S_WB) && (!out_valid || out_ready);
    echo_we  = wb_fire && !bypass;
    bq_we    = wb_fire && !bypass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-channel pointers
  logic [PW-1:0] wp      [NUM_CHANNELS];
  logic          wrapped [NUM_CHANNELS];
  logic          bq_ok   [NUM_CHANNELS];

  logic [CHW-1:0] ch_idx, ch_r;
  logic [PW-1:0]  wp_cur, rd_ptr, wp_r;
  logic [DW-1:0]  dly_ext, dly_c;
  logic [DW:0]    rd_diff;
  logic           in_range;

  assign ch_idx   = CHW'(in_word.chan_in);
  assign in_range = ({31'd0, in_word.chan_in}) < 32'(NUM_CHANNELS);
  assign wp_cur   = wp[ch_idx];
  assign dly_ext  = DW'(delay_samples);

  always_comb begin
    if (dly_ext == '0) begin
      dly_c = DW'(1);
    end else if (dly_ext > DW'(MAX_DELAY)) begin
      dly_c = DW'(MAX_DELAY);
    end else begin
      dly_c = dly_ext;
    end
    rd_diff = (DW + 1)'(wp_cur) - (DW + 1)'(dly_c);
    rd_ptr  = rd_diff[DW] ? PW'(rd_diff + (DW + 1)'(MAX_DELAY)) : PW'(rd_diff);
  end

  // memories
  logic [SW-1:0]     echo_mem [NUM_CHANNELS * MAX_DELAY];
  logic [2*TW-1:0]   bq_mem   [NUM_CHANNELS];
  logic [SW-1:0]     echo_rdata;
  logic [2*TW-1:0]   bq_rdata;
  logic [SW-1:0]     echo_wdata;
  logic [2*TW-1:0]   bq_wdata;

  always_ff @(posedge clk) begin
    if (echo_we) begin
      echo_mem[echo_addr(ch_r[0], wp_r)] <= echo_wdata;
    end
    if (in_fire) begin
      echo_rdata <= echo_mem[echo_addr(in_word.chan_in, rd_ptr)];
    end
  end

  always_ff @(posedge clk) begin
    if (bq_we) begin
      bq_mem[ch_r] <= bq_wdata;
    end
    if (in_fire) begin
      bq_rdata <= bq_mem[ch_idx];
    end
  end

  // captured word
  logic signed [SW-1:0] sample_r;
  logic                 chan_r;
  logic                 x_ok_r, bq_ok_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_word.sample_in;
      chan_r   <= in_word.chan_in;
      ch_r     <= ch_idx;
      wp_r     <= wp_cur;
      bypass   <= !in_range;
      x_ok_r   <= wrapped[ch_idx] || (rd_ptr < wp_cur);
      bq_ok_r  <= bq_ok[ch_idx];
    end
  end

  // datapath
  logic signed [SW-1:0]   x_s;
  logic signed [TW-1:0]   s1_s, s2_s, s1_r, s2_r;
  logic [SW-1:0]          mix_c, dry;
  logic signed [SW:0]     dry_s, mix_s;
  logic signed [49:0]     p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [47:0]     p_fb;
  logic signed [48:0]     p_dry, p_mix;
  logic signed [SW-1:0]   y_r;
  logic signed [28:0]     r_b0, r_b1, r_b2;
  logic signed [50:0]     d_b1, d_b2;
  logic signed [25:0]     r_fb;
  logic signed [49:0]     mix_sum;
  logic signed [26:0]     r_mix;
  logic signed [TW-1:0]   s1_new, s2_new;
  logic signed [SW-1:0]   res;

  assign x_s   = x_ok_r ? echo_rdata : '0;
  assign s1_s  = bq_ok_r ? bq_rdata[2*TW-1:TW] : '0;
  assign s2_s  = bq_ok_r ? bq_rdata[TW-1:0] : '0;
  assign mix_c = (mix_level > ffed_pkg::UNITY_Q23) ? ffed_pkg::UNITY_Q23 : mix_level;
  assign dry   = ffed_pkg::UNITY_Q23 - mix_c;
  assign dry_s = {1'b0, dry};
  assign mix_s = {1'b0, mix_c};

  always_ff @(posedge clk) begin
    unique case (state)
      ffed_pkg::S_MUL1: begin
        p_b0  <= 50'(coef_b0) * 50'(x_s);
        p_b1  <= 50'(coef_b1) * 50'(x_s);
        p_b2  <= 50'(coef_b2) * 50'(x_s);
        p_dry <= 49'(dry_s) * 49'(sample_r);
        s1_r  <= s1_s;
        s2_r  <= s2_s;
      end
      ffed_pkg::S_FILT: begin
        y_r <= sat24(40'(r_b0) + 40'(s1_r));
      end
      ffed_pkg::S_MUL2: begin
        p_a1  <= 50'(coef_a1) * 50'(y_r);
        p_a2  <= 50'(coef_a2) * 50'(y_r);
        p_fb  <= 48'(feedback_level) * 48'(y_r);
        p_mix <= 49'(mix_s) * 49'(y_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    r_b0       = 29'((51'(p_b0) + 51'sd2097152) >>> 22);
    d_b1       = 51'(p_b1) - 51'(p_a1);
    d_b2       = 51'(p_b2) - 51'(p_a2);
    r_b1       = 29'((d_b1 + 51'sd2097152) >>> 22);
    r_b2       = 29'((d_b2 + 51'sd2097152) >>> 22);
    s1_new     = sat32(40'(r_b1) + 40'(s2_r));
    s2_new     = sat32(40'(r_b2));
    r_fb       = 26'((49'(p_fb) + 49'sd4194304) >>> 23);
    echo_wdata = sat24(40'(r_fb) + 40'(sample_r));
    bq_wdata   = {s1_new, s2_new};
    mix_sum    = 50'(p_dry) + 50'(p_mix);
    r_mix      = 27'((mix_sum + 50'sd4194304) >>> 23);
    res        = bypass ? sample_r : sat24(40'(r_mix));
  end

  // pointer and valid bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wp[i]      <= '0;
        wrapped[i] <= 1'b0;
        bq_ok[i]   <= 1'b0;
      end
    end else if (echo_we) begin
      bq_ok[ch_r] <= 1'b1;
      if (wp_r == PW'(MAX_DELAY - 1)) begin
        wp[ch_r]      <= '0;
        wrapped[ch_r] <= 1'b1;
      end else begin
        wp[ch_r] <= wp_r + PW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_word.sample_out <= res;
      out_word.chan_out   <= chan_r;
    end
  end

  // checks
  a_wb_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##4 (state == ffed_pkg::S_WB))
    else $error("write back not reached four cycles after accept");

  a_out_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ffed_pkg::S_WB))
    else $error("output word raised outside write back");

  a_wb_to_idle: assert property (@(posedge clk) disable iff (rst)
    wb_fire |=> (state == ffed_pkg::S_IDLE) && out_valid)
    else $error("write back did not hand off the result");

endmodule
